// ----- rtl/core/trdc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trdc_pkg
// Shared types, constants and helpers for the transmit ring DMA chunker.
// ----------------------------------------------------------------------------
package trdc_pkg;

   localparam int DEPTH   = 256;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int BYTE_W  = 8;
   localparam int MODE_W  = 2;
   localparam int FIDX_W  = 8;
   localparam int FIDX_N  = 2 ** FIDX_W;

   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_W  = (PTR_W + 1)'(DEPTH);

   typedef logic [PTR_W-1:0] ptr_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH     = 2'd0,
      MODE_KICK     = 2'd1,
      MODE_COMPLETE = 2'd2,
      MODE_FETCH    = 2'd3
   } mode_type;

   typedef ptr_type wrap_tbl_type [FIDX_N];

   // fetch index folded into the buffer range, built at elaboration
   function automatic wrap_tbl_type build_wrap_tbl();
      wrap_tbl_type t;
      for (int i = 0; i < FIDX_N; i++) begin
         t[i] = PTR_W'(i % DEPTH);
      end
      return t;
   endfunction

   localparam wrap_tbl_type FETCH_WRAP = build_wrap_tbl();

   function automatic ptr_type next_slot(input ptr_type p);
      return (p == LAST_POS) ? '0 : p + 1'b1;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tx_ring_dma_chunker_top.sv -----
// Pipeline: a result passes the stage-1 and output registers after its input beat is accepted.
// Throughput: one beat per cycle while the result side keeps up; stage 1
//   covers the registered read port of the byte store.
// Reset: positions, chunk length, busy flag and valid bits clear on a
//   synchronous reset; the byte store is not cleared and needs no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// tx_ring_dma_chunker_top
// Transmit ring buffer that feeds a DMA engine with contiguous chunks.
// ----------------------------------------------------------------------------
module tx_ring_dma_chunker_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [trdc_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [trdc_pkg::BYTE_W-1:0]    req_data_byte,
   input  wire logic [trdc_pkg::FIDX_W-1:0]    req_fetch_index,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_accepted,
   output logic                                rsp_full_res,
   output logic                                rsp_start_res,
   output logic      [7:0]                     rsp_start_index,
   output logic      [7:0]                     rsp_start_length,
   output logic      [trdc_pkg::BYTE_W-1:0]    rsp_read_data
);
   import trdc_pkg::*;

   // ring state
   ptr_type wp_ff, wp_in;
   ptr_type rp_ff, rp_in;
   ptr_type chunk_ff, chunk_in;
   logic    busy_ff, busy_in;

   // stage 1: result fields waiting for the store read
   logic        s1_valid_ff;
   logic        s1_fetch_ff;
   logic        s1_acc_ff;
   logic        s1_full_ff;
   logic        s1_start_ff;
   logic [7:0]  s1_sidx_ff;
   logic [7:0]  s1_slen_ff;

   // output register
   logic              out_valid_ff;
   logic              out_acc_ff;
   logic              out_full_ff;
   logic              out_start_ff;
   logic [7:0]        out_sidx_ff;
   logic [7:0]        out_slen_ff;
   logic [BYTE_W-1:0] out_rdata_ff;

   logic              req_fire;
   logic              out_free;
   logic              s1_adv;
   mode_type          mode;
   logic              wr_en;
   logic              rd_en;
   ptr_type           rd_addr;
   logic [BYTE_W-1:0] ram_q;

   logic              acc;
   logic              started;
   ptr_type           sidx;
   ptr_type           slen;
   ptr_type           rp_mid;
   logic              busy_mid;
   ptr_type           chunk_mid;
   logic [PTR_W:0]    rp_sum;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;
   assign mode      = mode_type'(req_mode);

   assign rp_sum = {1'b0, rp_ff} + {1'b0, chunk_ff};

   always_comb begin
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      chunk_in  = chunk_ff;
      busy_in   = busy_ff;
      acc       = 1'b0;
      started   = 1'b0;
      sidx      = '0;
      slen      = '0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rp_mid    = rp_ff;
      busy_mid  = busy_ff;
      chunk_mid = chunk_ff;

      // completion retires the running chunk before any new start
      if (mode == MODE_COMPLETE && busy_ff) begin
         if (chunk_ff != '0) begin
            rp_mid    = (rp_sum >= DEPTH_W) ? PTR_W'(rp_sum - DEPTH_W) : PTR_W'(rp_sum);
            chunk_mid = '0;
         end
         busy_mid = 1'b0;
      end

      unique case (mode) inside
         MODE_PUSH: begin
            if (next_slot(wp_ff) != rp_ff) begin
               wr_en = req_fire;
               wp_in = next_slot(wp_ff);
               acc   = 1'b1;
            end
         end
         MODE_KICK, MODE_COMPLETE: begin
            rp_in    = rp_mid;
            busy_in  = busy_mid;
            chunk_in = chunk_mid;
            if (!busy_mid && rp_mid != wp_ff) begin
               started  = 1'b1;
               sidx     = rp_mid;
               slen     = (wp_ff > rp_mid) ? wp_ff - rp_mid : PTR_W'(DEPTH_W - {1'b0, rp_mid});
               chunk_in = slen;
               busy_in  = 1'b1;
            end
         end
         MODE_FETCH: begin
            rd_en = req_fire;
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = FETCH_WRAP[req_fetch_index];

   trdc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         chunk_ff     <= '0;
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            wp_ff    <= wp_in;
            rp_ff    <= rp_in;
            chunk_ff <= chunk_in;
            busy_ff  <= busy_in;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_fetch_ff <= (mode == MODE_FETCH);
         s1_acc_ff   <= acc;
         s1_full_ff  <= (next_slot(wp_in) == rp_in);
         s1_start_ff <= started;
         s1_sidx_ff  <= 8'(sidx);
         s1_slen_ff  <= 8'(slen);
      end
      if (s1_adv) begin
         out_acc_ff   <= s1_acc_ff;
         out_full_ff  <= s1_full_ff;
         out_start_ff <= s1_start_ff;
         out_sidx_ff  <= s1_sidx_ff;
         out_slen_ff  <= s1_slen_ff;
         out_rdata_ff <= s1_fetch_ff ? ram_q : '0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_accepted     = out_acc_ff;
   assign rsp_full_res     = out_full_ff;
   assign rsp_start_res    = out_start_ff;
   assign rsp_start_index  = out_sidx_ff;
   assign rsp_start_length = out_slen_ff;
   assign rsp_read_data    = out_rdata_ff;

`ifndef SYNTHESIS
   // chunk length is nonzero exactly while a transfer runs
   a_chunk_busy: assert property (@(posedge clock) disable iff (reset)
      (busy_ff == (chunk_ff != '0)))
      else $error("chunk length and busy flag disagree");

   // a running chunk holds data, so the ring is never empty while busy
   a_busy_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (wp_ff != rp_ff))
      else $error("ring empty while a chunk is in flight");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (wp_ff <= LAST_POS) && (rp_ff <= LAST_POS))
      else $error("ring position out of range");

   // a push never starts a chunk
   a_push_no_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_start_res))
      else $error("stored push reported a chunk start");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff)
      else $error("pending beat lost in stage 1");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/trdc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
